// ----- rtl/core/fbpa_pkg.sv -----
`default_nettype none
package fbpa_pkg;

    localparam int POOL_DEPTH  = 256;
    localparam int IDX_W       = $clog2(POOL_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    typedef enum logic [2:0] {
        ST_ALLOCATED     = 3'd0,
        ST_EXHAUSTED     = 3'd1,
        ST_FREED         = 3'd2,
        ST_NOT_ALLOCATED = 3'd3,
        ST_OUT_OF_RANGE  = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        K_ALLOC  = 2'd0,
        K_FREE   = 2'd1,
        K_REJECT = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [IDX_W-1:0]  idx;
    } t_req;

endpackage
`default_nettype wire

// ----- rtl/core/fbpa_front.sv -----
`default_nettype none
module fbpa_front
    import fbpa_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic             i_mode,
    input  wire logic [IDX_W-1:0] i_free_index,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [CNT_W-1:0] i_cfg_data,
    input  wire logic             i_q_full,
    output logic                  o_q_push,
    output t_req                  o_q_item,
    output logic [CNT_W-1:0]      o_limit
);

    logic [CNT_W-1:0] r_num_entries;
    logic [CNT_W-1:0] n_num_entries;

    always_comb begin
        n_num_entries = r_num_entries;
        if (i_cfg_valid) begin
            n_num_entries = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_entries <= CNT_W'(POOL_DEPTH);
        end else begin
            r_num_entries <= n_num_entries;
        end
    end

    // saturate the configured count to the pool size
    assign o_limit = (r_num_entries > CNT_W'(POOL_DEPTH)) ? CNT_W'(POOL_DEPTH) : r_num_entries;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !i_q_full;
    assign o_q_push    = i_in_valid && !i_q_full;

    always_comb begin
        o_q_item.idx = i_free_index;
        if (!i_mode) begin
            o_q_item.kind = K_ALLOC;
        end else if ({1'b0, i_free_index} >= o_limit) begin
            o_q_item.kind = K_REJECT;
        end else begin
            o_q_item.kind = K_FREE;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/fbpa_queue.sv -----
`default_nettype none
module fbpa_queue
    import fbpa_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_req i_item,
    output logic      o_full,
    output logic      o_valid,
    output t_req      o_item,
    input  wire logic i_pop
);

    t_req              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_wptr;
    logic [QPTR_W-1:0] n_rptr;
    logic [QCNT_W-1:0] n_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + QPTR_W'(1);
        end
        if (i_pop) begin
            n_rptr = (r_rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + QPTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/fbpa_back.sv -----
`default_nettype none
module fbpa_back
    import fbpa_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_q_valid,
    input  wire t_req             i_q_item,
    output logic                  o_q_pop,
    input  wire logic [CNT_W-1:0] i_limit,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output logic                  o_granted,
    output logic [IDX_W-1:0]      o_block_index,
    output logic [CNT_W-1:0]      o_used_now,
    output logic [2:0]            o_status
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_ALLOC = 3'b010,
        S_FREE  = 3'b100
    } t_state;

    t_state            r_state;
    t_state            n_state;
    logic [CNT_W-1:0]  r_free_head;
    logic [CNT_W-1:0]  n_free_head;
    logic [CNT_W-1:0]  r_used;
    logic [CNT_W-1:0]  n_used;
    logic [POOL_DEPTH-1:0] r_alloc_bits;
    logic [POOL_DEPTH-1:0] n_alloc_bits;
    logic [POOL_DEPTH-1:0] r_link_vld;
    logic [POOL_DEPTH-1:0] n_link_vld;
    logic              r_out_valid;
    logic              n_out_valid;
    logic              r_granted;
    logic              n_granted;
    logic [IDX_W-1:0]  r_block_index;
    logic [IDX_W-1:0]  n_block_index;
    logic [CNT_W-1:0]  r_used_now;
    logic [CNT_W-1:0]  n_used_now;
    t_status           r_status;
    t_status           n_status;

    logic [CNT_W-1:0]  r_link_mem [POOL_DEPTH];
    logic [CNT_W-1:0]  r_rd_data;
    logic              r_rd_vld;
    logic [IDX_W-1:0]  r_rd_addr;
    logic              r_chk_bit;
    logic [IDX_W-1:0]  r_chk_idx;

    logic              out_free;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [CNT_W-1:0]  wr_data;
    logic              rd_en;
    logic              chk_en;
    logic [CNT_W-1:0]  link_next;

    assign out_free  = !r_out_valid || i_out_ready;
    assign link_next = r_rd_vld ? r_rd_data : CNT_W'(r_rd_addr) + CNT_W'(1);

    always_comb begin
        n_state       = r_state;
        n_free_head   = r_free_head;
        n_used        = r_used;
        n_alloc_bits  = r_alloc_bits;
        n_link_vld    = r_link_vld;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_granted     = r_granted;
        n_block_index = r_block_index;
        n_used_now    = r_used_now;
        n_status      = r_status;
        o_q_pop       = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = r_chk_idx;
        wr_data       = r_free_head;
        rd_en         = 1'b0;
        chk_en        = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid && out_free) begin
                    o_q_pop = 1'b1;
                    case (i_q_item.kind)
                        K_ALLOC: begin
                            if (r_used >= i_limit || r_free_head[IDX_W]) begin
                                n_out_valid   = 1'b1;
                                n_granted     = 1'b0;
                                n_block_index = '0;
                                n_used_now    = r_used;
                                n_status      = ST_EXHAUSTED;
                            end else begin
                                rd_en   = 1'b1;
                                n_state = S_ALLOC;
                            end
                        end
                        K_FREE: begin
                            chk_en  = 1'b1;
                            n_state = S_FREE;
                        end
                        default: begin
                            n_out_valid   = 1'b1;
                            n_granted     = 1'b0;
                            n_block_index = i_q_item.idx;
                            n_used_now    = r_used;
                            n_status      = ST_OUT_OF_RANGE;
                        end
                    endcase
                end
            end
            S_ALLOC: begin
                n_free_head             = link_next;
                n_alloc_bits[r_rd_addr] = 1'b1;
                n_used                  = r_used + CNT_W'(1);
                n_out_valid             = 1'b1;
                n_granted               = 1'b1;
                n_block_index           = r_rd_addr;
                n_used_now              = n_used;
                n_status                = ST_ALLOCATED;
                n_state                 = S_IDLE;
            end
            S_FREE: begin
                n_out_valid   = 1'b1;
                n_block_index = r_chk_idx;
                if (r_chk_bit) begin
                    wr_en                   = 1'b1;
                    n_link_vld[r_chk_idx]   = 1'b1;
                    n_alloc_bits[r_chk_idx] = 1'b0;
                    n_free_head             = CNT_W'(r_chk_idx);
                    n_used = (r_used != '0) ? r_used - CNT_W'(1) : r_used;
                    n_granted               = 1'b1;
                    n_used_now              = n_used;
                    n_status                = ST_FREED;
                end else begin
                    n_granted  = 1'b0;
                    n_used_now = r_used;
                    n_status   = ST_NOT_ALLOCATED;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_free_head  <= '0;
            r_used       <= '0;
            r_alloc_bits <= '0;
            r_link_vld   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_free_head  <= n_free_head;
            r_used       <= n_used;
            r_alloc_bits <= n_alloc_bits;
            r_link_vld   <= n_link_vld;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_granted     <= n_granted;
        r_block_index <= n_block_index;
        r_used_now    <= n_used_now;
        r_status      <= n_status;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_link_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_link_mem[r_free_head[IDX_W-1:0]];
            r_rd_vld  <= r_link_vld[r_free_head[IDX_W-1:0]];
            r_rd_addr <= r_free_head[IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (chk_en) begin
            r_chk_bit <= r_alloc_bits[i_q_item.idx];
            r_chk_idx <= i_q_item.idx;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_granted     = r_granted;
    assign o_block_index = r_block_index;
    assign o_used_now    = r_used_now;
    assign o_status      = r_status;

endmodule
`default_nettype wire

// ----- rtl/core/fixed_block_pool_allocator.sv -----
// Fixed-size block pool allocator: hands out block indices from a LIFO free list kept in a
// link memory and takes them back, rejecting frees of blocks that are out of range or not
// currently allocated. Requests enter a two-deep queue and are served in order, one result
// per request. An allocate that finds the pool exhausted, or an out-of-range free, is
// answered straight from the idle state; a granted allocate first waits on the registered
// read of the link memory at the free-list head, and any other free on the registered
// read of the block's allocated bit.
// The configured block count takes effect for requests accepted after the write, and is to
// be written only while no request is outstanding.
`default_nettype none
module fixed_block_pool_allocator
    import fbpa_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic             i_mode,
    input  wire logic [IDX_W-1:0] i_free_index,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output logic                  o_granted,
    output logic [IDX_W-1:0]      o_block_index,
    output logic [CNT_W-1:0]      o_used_now,
    output logic [2:0]            o_status,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [CNT_W-1:0] i_cfg_data
);

    logic             q_full;
    logic             q_push;
    t_req             q_in_item;
    logic             q_valid;
    t_req             q_out_item;
    logic             q_pop;
    logic [CNT_W-1:0] limit;

    fbpa_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_mode       (i_mode),
        .i_free_index (i_free_index),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_q_full     (q_full),
        .o_q_push     (q_push),
        .o_q_item     (q_in_item),
        .o_limit      (limit)
    );

    fbpa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_out_item),
        .i_pop   (q_pop)
    );

    fbpa_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_item      (q_out_item),
        .o_q_pop       (q_pop),
        .i_limit       (limit),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_granted     (o_granted),
        .o_block_index (o_block_index),
        .o_used_now    (o_used_now),
        .o_status      (o_status)
    );

endmodule
`default_nettype wire
